// ===== hdl/pgr_pkg.sv =====
// ----------------------------------------------------------------------------
// pgr_pkg
// Shared codes for the pan gesture recognizer.
// ----------------------------------------------------------------------------
package pgr_pkg;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_MOVE  = 2'd1;
	localparam logic [1:0] CMD_END   = 2'd2;
	localparam logic [1:0] CMD_OTHER = 2'd3;

	localparam logic [2:0] ACT_IGNORE  = 3'd0;
	localparam logic [2:0] ACT_MAYBE   = 3'd1;
	localparam logic [2:0] ACT_TRIGGER = 3'd2;
	localparam logic [2:0] ACT_FINISH  = 3'd3;
	localparam logic [2:0] ACT_CANCEL  = 3'd4;

	localparam logic [1:0] PH_NONE     = 2'd0;
	localparam logic [1:0] PH_STARTED  = 2'd1;
	localparam logic [1:0] PH_UPDATED  = 2'd2;
	localparam logic [1:0] PH_FINISHED = 2'd3;

	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_WAIT   = 2'd1;
	localparam logic [1:0] MODE_MOVING = 2'd2;

	localparam logic [1:0] REG_BOUND_X = 2'd0;
	localparam logic [1:0] REG_BOUND_Y = 2'd1;
	localparam logic [1:0] REG_BOUND_W = 2'd2;
	localparam logic [1:0] REG_BOUND_H = 2'd3;

endpackage

// ===== hdl/pgr_front.sv =====
// ----------------------------------------------------------------------------
// pgr_front
// Input stage: clamps the point count and sums the valid points.
// Outputs the clamped count and the sums; the core packs them into a queue entry.
// ----------------------------------------------------------------------------
module pgr_front #(
	parameter int MAX_POINTS = 4,
	parameter int COORD_BITS = 16
) (
	input  logic [2:0]                          point_count,
	input  logic [MAX_POINTS-1:0][COORD_BITS-1:0] px,
	input  logic [MAX_POINTS-1:0][COORD_BITS-1:0] py,
	output logic [2:0]                          n_clamped,
	output logic signed [COORD_BITS+2:0]        sum_x,
	output logic signed [COORD_BITS+2:0]        sum_y
);
	localparam logic [2:0] MAXP = 3'(MAX_POINTS);

	always_comb begin
		n_clamped = point_count;
		if (point_count == 3'd0) n_clamped = 3'd1;
		if (point_count > MAXP) n_clamped = MAXP;
		sum_x = '0;
		sum_y = '0;
		for (int i = 0; i < MAX_POINTS; i++) begin
			if (3'(i) < n_clamped) begin
				sum_x = sum_x + (COORD_BITS+3)'($signed(px[i]));
				sum_y = sum_y + (COORD_BITS+3)'($signed(py[i]));
			end
		end
	end
endmodule

// ===== hdl/pgr_back.sv =====
// ----------------------------------------------------------------------------
// pgr_back
// Execution sequencer: holds the gesture state and works one queued event
// through a few steps (divide, angle test, update, report).
// ----------------------------------------------------------------------------
module pgr_back #(
	parameter int MAX_POINTS = 4,
	parameter int COORD_BITS = 16,
	parameter int QW = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  logic [QW-1:0]            q_data,
	output logic                     q_take,
	input  logic signed [15:0]       bound_x,
	input  logic signed [15:0]       bound_y,
	input  logic [14:0]              bound_width,
	input  logic [14:0]              bound_height,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic [2:0]               action,
	output logic [1:0]               phase,
	output logic signed [COORD_BITS-1:0] center_x,
	output logic signed [COORD_BITS-1:0] center_y,
	output logic signed [COORD_BITS:0]   delta_x,
	output logic signed [COORD_BITS:0]   delta_y,
	output logic [3:0]               side_bits,
	output logic [2:0]               touch_count
);
	localparam int CB = COORD_BITS;
	localparam int SW = CB + 3;
	localparam int PW = 2 * MAX_POINTS * CB;
	localparam int DW = CB + 1;          // displacement
	localparam int NW = 2 * DW + 1;      // squared norm
	localparam int MW = 2 * NW + 4;      // product compare

	// step codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_ANG1 = 3'd2;
	localparam logic [2:0] ST_ANG2 = 3'd3;
	localparam logic [2:0] ST_EXEC = 3'd4;

	// unpack queue entry: cmd, n, tiny, dk, points, sum_x, sum_y
	logic [1:0] e_cmd;
	logic [2:0] e_n;
	logic       e_tiny, e_dk;
	logic [PW-1:0] e_pts;
	logic signed [SW-1:0] e_sx, e_sy;
	assign {e_sy, e_sx, e_pts, e_dk, e_tiny, e_n, e_cmd} = q_data;

	function automatic logic signed [CB-1:0] pt(input logic [PW-1:0] p, input int k);
		pt = p[k*CB +: CB];
	endfunction

	logic [2:0] st_q;
	logic [1:0] mode_q;
	logic [MAX_POINTS*2-1:0][CB-1:0] anc_q;
	logic signed [CB-1:0] cx_q, cy_q;
	logic [3:0] side_q;
	logic [2:0] cnt_q;

	// truncating division by n (1..4): n=3 via reciprocal, others by shift
	function automatic logic signed [CB-1:0] div_n(input logic signed [SW-1:0] s,
			input logic [2:0] n);
		logic [SW-1:0] a;
		logic [SW-1:0] qv;
		logic [2*SW+1:0] pr;
		a = s[SW-1] ? SW'(-s) : SW'(s);
		pr = '0;
		case (n)
			3'd2: qv = a >> 1;
			3'd3: begin
				pr = (2*SW+2)'(a) * (2*SW+2)'(((1 << (SW+1)) + 2) / 3);
				qv = SW'(pr >> (SW + 1));
			end
			3'd4: qv = a >> 2;
			default: qv = a;
		endcase
		div_n = s[SW-1] ? CB'(-$signed(qv)) : CB'(qv);
	endfunction

	logic signed [CB-1:0] avx_q, avy_q;
	logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q;
	logic [NW-1:0] na_q, nb_q;
	logic signed [NW:0] dot_q;
	logic pass_q;
	logic [MW-1:0] lhs, rhs;

	always_comb begin
		lhs = MW'(dot_q) * MW'(dot_q) * MW'(4);
		rhs = MW'(na_q) * MW'(nb_q) * MW'(3);
	end

	// side pruning
	logic signed [DW-1:0] dx, dy;
	logic [NW-1:0] x2, y2;
	logic horiz, vert;
	logic [3:0] pruned, side_new;
	logic signed [CB+1:0] rx, by2;
	always_comb begin
		dx = DW'(avx_q) - DW'(cx_q);
		dy = DW'(avy_q) - DW'(cy_q);
		x2 = NW'(dx * dx);
		y2 = NW'(dy * dy);
		horiz = ({2'b0, x2} >= 3 * {2'b0, y2});
		vert  = ({2'b0, y2} >= 3 * {2'b0, x2});
		pruned = side_q;
		if (!(!dx[DW-1] && horiz)) pruned[0] = 1'b0;
		if (!((dx[DW-1] || dx == 0) && horiz)) pruned[1] = 1'b0;
		if (!(!dy[DW-1] && vert)) pruned[2] = 1'b0;
		if (!((dy[DW-1] || dy == 0) && vert)) pruned[3] = 1'b0;
		rx  = (CB+2)'(bound_x) + (CB+2)'($signed({1'b0, bound_width}));
		by2 = (CB+2)'(bound_y) + (CB+2)'($signed({1'b0, bound_height}));
		side_new = '0;
		if (bound_width != 0 && bound_height != 0) begin
			side_new[0] = pt(e_pts, 0) < bound_x;
			side_new[1] = (CB+2)'(pt(e_pts, 0)) > rx;
			side_new[2] = pt(e_pts, 1) < bound_y;
			side_new[3] = (CB+2)'(pt(e_pts, 1)) > by2;
		end
	end

	// execute decision for the queued request
	logic [2:0] act_d;
	logic [1:0] ph_d, mode_d;
	logic first_d, restart_d, upd_d, prune_d;
	always_comb begin
		act_d = pgr_pkg::ACT_CANCEL;
		ph_d = pgr_pkg::PH_NONE;
		mode_d = mode_q;
		first_d = 1'b0;
		restart_d = 1'b0;
		upd_d = 1'b0;
		unique case (mode_q)
			pgr_pkg::MODE_IDLE: if (e_cmd == pgr_pkg::CMD_START) begin
				mode_d = pgr_pkg::MODE_WAIT;
				first_d = 1'b1;
				act_d = pgr_pkg::ACT_MAYBE;
			end
			pgr_pkg::MODE_WAIT: begin
				if (e_cmd == pgr_pkg::CMD_START) begin
					restart_d = 1'b1;
					act_d = pgr_pkg::ACT_MAYBE;
				end else if (e_cmd == pgr_pkg::CMD_MOVE) begin
					if (e_tiny || (e_n == 3'd2 && !e_dk))
						act_d = pgr_pkg::ACT_IGNORE;
					else if (e_n == 3'd2 && !pass_q)
						mode_d = pgr_pkg::MODE_IDLE;
					else begin
						mode_d = pgr_pkg::MODE_MOVING;
						ph_d = pgr_pkg::PH_STARTED;
						act_d = pgr_pkg::ACT_TRIGGER;
						upd_d = 1'b1;
					end
				end else mode_d = pgr_pkg::MODE_IDLE;
			end
			default: begin
				if (e_cmd == pgr_pkg::CMD_MOVE) begin
					ph_d = pgr_pkg::PH_UPDATED;
					act_d = pgr_pkg::ACT_TRIGGER;
					upd_d = 1'b1;
				end else if (e_cmd == pgr_pkg::CMD_END) begin
					ph_d = pgr_pkg::PH_FINISHED;
					act_d = pgr_pkg::ACT_FINISH;
					upd_d = 1'b1;
					mode_d = pgr_pkg::MODE_IDLE;
				end else mode_d = pgr_pkg::MODE_IDLE;
			end
		endcase
		// only the first move prunes, and a zero delta keeps every side
		prune_d = (ph_d == pgr_pkg::PH_STARTED) && (dx != 0 || dy != 0);
	end

	assign q_take = (st_q == ST_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			mode_q <= pgr_pkg::MODE_IDLE;
			anc_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			side_q <= '0;
			cnt_q <= '0;
			res_valid <= 1'b0;
			action <= pgr_pkg::ACT_IGNORE;
			phase <= pgr_pkg::PH_NONE;
			delta_x <= '0;
			delta_y <= '0;
			avx_q <= '0;
			avy_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			bx_q <= '0;
			by_q <= '0;
			na_q <= '0;
			nb_q <= '0;
			dot_q <= '0;
			pass_q <= 1'b0;
		end else begin
			if (st_q == ST_EXEC) res_valid <= 1'b1;
			else if (res_valid && res_ready) res_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (q_valid && !(res_valid && !res_ready)) st_q <= ST_DIV;
				ST_DIV: begin
					avx_q <= div_n(e_sx, e_n);
					avy_q <= div_n(e_sy, e_n);
					ax_q <= DW'(pt(e_pts, 0)) - DW'($signed(anc_q[0]));
					ay_q <= DW'(pt(e_pts, 1)) - DW'($signed(anc_q[1]));
					bx_q <= DW'(pt(e_pts, 2)) - DW'($signed(anc_q[2]));
					by_q <= DW'(pt(e_pts, 3)) - DW'($signed(anc_q[3]));
					st_q <= ST_ANG1;
				end
				ST_ANG1: begin
					na_q <= NW'(ax_q * ax_q) + NW'(ay_q * ay_q);
					nb_q <= NW'(bx_q * bx_q) + NW'(by_q * by_q);
					dot_q <= (NW+1)'(ax_q * bx_q) + (NW+1)'(ay_q * by_q);
					st_q <= ST_ANG2;
				end
				ST_ANG2: begin
					pass_q <= (na_q == 0) || (nb_q == 0) ||
						(!dot_q[NW] && lhs >= rhs);
					st_q <= ST_EXEC;
				end
				ST_EXEC: begin
					action <= act_d;
					phase <= ph_d;
					mode_q <= mode_d;
					delta_x <= upd_d ? dx : '0;
					delta_y <= upd_d ? dy : '0;
					st_q <= ST_IDLE;
					if (first_d) begin
						cnt_q <= e_n;
						anc_q[0] <= pt(e_pts, 0);
						anc_q[1] <= pt(e_pts, 1);
						cx_q <= pt(e_pts, 0);
						cy_q <= pt(e_pts, 1);
						side_q <= side_new;
					end else begin
						if (restart_d) begin
							cnt_q <= e_n;
							for (int i = 0; i < 2*MAX_POINTS; i++)
								if (3'(i/2) < e_n) anc_q[i] <= e_pts[i*CB +: CB];
						end
						if (restart_d || upd_d) begin
							cx_q <= avx_q;
							cy_q <= avy_q;
						end
						if (prune_d) side_q <= pruned;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// center and side fields read the state registers after the update
	assign center_x = cx_q;
	assign center_y = cy_q;
	assign side_bits = side_q;
	assign touch_count = cnt_q;

	a_take_once: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |=> !q_take) else $error("queue entry taken twice");
	a_res_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |=> res_valid) else $error("no result after execute");
	a_mode_ok: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 2'd3) else $error("bad mode");
endmodule

// ===== hdl/pan_gesture_recognizer_core.sv =====
// ----------------------------------------------------------------------------
// pan_gesture_recognizer_core
// Pan gesture recognizer: touch events in, one result per event out.
// ----------------------------------------------------------------------------
// One request in gives exactly one result out. The front stage clamps the
// point count and sums the points, then parks the request in a two-entry
// queue; the back sequencer takes it through division, the squared-product
// angle test and the state update in its steps (pick up the queue head,
// divide, two angle-test steps, update). The result sits in an output
// register so a new request is accepted while the previous result waits.
// The user writes the bounds registers through cfg_we/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this.
module pan_gesture_recognizer_core #(
	parameter int MAX_POINTS = 4,
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd, point_count, tiny_move, direction_known, p0_x, p0_y .. p3_x, p3_y
	input  logic [((7+2*MAX_POINTS*COORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// action, phase, center_x, center_y, delta_x, delta_y, side_bits, touch_count
	output logic [((12+4*COORD_BITS+2+7)/8)*8-1:0] m_tdata
);
	localparam int CB = COORD_BITS;
	localparam int PW = 2 * MAX_POINTS * CB;
	localparam int SW = CB + 3;
	localparam int QW = 7 + PW + 2 * SW;
	localparam int OW = 12 + 4 * CB + 2;

	logic signed [15:0] bx_q, by_q;
	logic [14:0] bw_q, bh_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bx_q <= '0; by_q <= '0; bw_q <= '0; bh_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pgr_pkg::REG_BOUND_X: bx_q <= cfg_data;
				pgr_pkg::REG_BOUND_Y: by_q <= cfg_data;
				pgr_pkg::REG_BOUND_W: bw_q <= cfg_data[14:0];
				default: bh_q <= cfg_data[14:0];
			endcase
		end
	end

	logic [MAX_POINTS-1:0][CB-1:0] px, py;
	always_comb
		for (int i = 0; i < MAX_POINTS; i++) begin
			px[i] = s_tdata[7 + 2*i*CB +: CB];
			py[i] = s_tdata[7 + (2*i+1)*CB +: CB];
		end

	logic [2:0] n_c;
	logic signed [SW-1:0] sx, sy;
	pgr_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(CB)) u_front (
		.point_count(s_tdata[4:2]), .px(px), .py(py),
		.n_clamped(n_c), .sum_x(sx), .sum_y(sy));

	// two-entry request queue
	logic [1:0][QW-1:0] q_mem_q;
	logic [1:0] q_cnt_q;
	logic q_rd_q, q_wr_q;
	logic q_take;
	logic push;
	assign s_tready = (q_cnt_q != 2'd2);
	assign push = s_tvalid && s_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q <= '0; q_rd_q <= 1'b0; q_wr_q <= 1'b0;
		end else begin
			if (push) begin
				q_mem_q[q_wr_q] <= {sy, sx, s_tdata[7 +: PW], s_tdata[6:5], n_c,
					s_tdata[1:0]};
				q_wr_q <= !q_wr_q;
			end
			if (q_take) q_rd_q <= !q_rd_q;
			q_cnt_q <= q_cnt_q + 2'(push) - 2'(q_take);
		end
	end

	logic [2:0] action, touch_count;
	logic [1:0] phase;
	logic [CB-1:0] cxo, cyo;
	logic [CB:0] dxo, dyo;
	logic [3:0] sb;
	pgr_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(CB), .QW(QW)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_cnt_q != 2'd0),
		.q_data(q_mem_q[q_rd_q]), .q_take(q_take),
		.bound_x(bx_q), .bound_y(by_q), .bound_width(bw_q), .bound_height(bh_q),
		.res_valid(m_tvalid), .res_ready(m_tready), .action(action), .phase(phase),
		.center_x(cxo), .center_y(cyo), .delta_x(dxo), .delta_y(dyo),
		.side_bits(sb), .touch_count(touch_count));

	assign m_tdata = {{($bits(m_tdata)-OW){1'b0}}, touch_count, sb, dyo, dxo, cyo, cxo,
		phase, action};
endmodule
